// ===== rtl/refcounted_slot_pool_defines.svh =====
// ----------------------------------------------------------------------------
// refcounted_slot_pool_defines.svh
// Assertion macros used by the checker file of the slot pool.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_POOL_DEFINES_SVH
`define REFCOUNTED_SLOT_POOL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types, operation and status codes and word layout of the slot pool.
// ----------------------------------------------------------------------------
package rcsp_pkg;

    // Default sizing
    localparam int SLOT_COUNT_DEF = 256;
    localparam int PAGE_BYTES_DEF = 16384;
    localparam int COUNT_BITS_DEF = 16;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int REFCNT_W = 16;
    localparam int OFFSET_W = 22;
    localparam int USED_W   = 9;

    localparam int IN_BITS  = MODE_W + INDEX_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + INDEX_W + REFCNT_W + OFFSET_W + USED_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADDREF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFFSET  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEVER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture input word, launch memory reads
        logic commit;   // update state and memories, load output register
    } ctrl_cmd_t;

endpackage

// ===== rtl/refcounted_slot_pool.sv =====
// ----------------------------------------------------------------------------
// refcounted_slot_pool
// Reference-counted page slot pool with a LIFO free stack.
// ----------------------------------------------------------------------------
// For each command word, in the cycle it is accepted the count
// table and the top of the free stack are read from their RAMs; in the
// commit cycle the count is updated, the stack is pushed or popped and the
// result word is loaded into the output register. This read-then-write
// pass over the RAMs keeps one word in work at a time. A new command is
// taken while the previous result is still waiting in the output register;
// the update cycle waits only if that register is still full. Reset mode
// clears the counters in the same read-then-write pass; the RAMs need no
// clearing pass since only entries below the high-water mark and the stack
// top are ever used.
// ----------------------------------------------------------------------------
module refcounted_slot_pool #(
    parameter int SLOT_COUNT = rcsp_pkg::SLOT_COUNT_DEF,
    parameter int PAGE_BYTES = rcsp_pkg::PAGE_BYTES_DEF,
    parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata: mode[2:0], slot_index[10:3], zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rcsp_pkg::IN_W-1:0]  s_tdata,
    // m_tdata: status[2:0], slot_out[10:3], ref_count[26:11],
    //          page_offset[48:27], used_slots[57:49], slot_freed[58], zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rcsp_pkg::OUT_W-1:0] m_tdata
);

    import rcsp_pkg::*;

    ctrl_cmd_t cmd;

    rcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rcsp_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== rtl/rcsp_ram.sv =====
// ----------------------------------------------------------------------------
// rcsp_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rcsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcsp_ctrl
// Sequencer: accept a word, then commit it once the output register is free.
// ----------------------------------------------------------------------------
module rcsp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rcsp_pkg::ctrl_cmd_t cmd
);

    import rcsp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign cmd.load   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.commit = (state_reg == S_EXEC) && out_free;

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_EXEC;
                    end
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rcsp_datapath.sv =====
// ----------------------------------------------------------------------------
// rcsp_datapath
// Count table, free stack, pool counters and output word register.
// ----------------------------------------------------------------------------
module rcsp_datapath #(
    parameter int SLOT_COUNT = rcsp_pkg::SLOT_COUNT_DEF,
    parameter int PAGE_BYTES = rcsp_pkg::PAGE_BYTES_DEF,
    parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rcsp_pkg::ctrl_cmd_t      cmd,
    input  logic [rcsp_pkg::IN_W-1:0]  s_tdata,
    output logic [rcsp_pkg::OUT_W-1:0] m_tdata
);

    import rcsp_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Captured input word
    logic [MODE_W-1:0]  mode_reg;
    logic [INDEX_W-1:0] idx_reg;

    // Pool counters
    logic [CNT_W-1:0] top_reg,  top_next;
    logic [CNT_W-1:0] hw_reg,   hw_next;
    logic [CNT_W-1:0] used_reg, used_next;

    // Output word
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  slot_reg;
    logic [REFCNT_W-1:0] refcnt_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [USED_W-1:0]   used_out_reg;
    logic                freed_reg;

    // Memory ports
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [SLOT_W-1:0]     stk_rdata;
    logic                  ref_we;
    logic [SLOT_W-1:0]     ref_waddr;
    logic [COUNT_BITS-1:0] ref_wdata;
    logic                  stk_we;
    logic [SLOT_W-1:0]     stk_waddr;

    // Result of the current operation
    logic [STATUS_W-1:0]   st;
    logic [INDEX_W-1:0]    slot_o;
    logic [COUNT_BITS-1:0] cnt_o;
    logic                  off_en;
    logic [SLOT_W-1:0]     off_slot;
    logic                  freed;
    logic                  known;
    logic [SLOT_W-1:0]     grant;
    logic [SLOT_W-1:0]     idx_s;
    logic [31:0]           prod;

    rcsp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (cmd.load),
        .raddr (SLOT_W'(s_tdata[IN_BITS-1:MODE_W])),
        .rdata (cnt_rdata)
    );

    rcsp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (idx_s),
        .re    (cmd.load),
        .raddr (SLOT_W'(top_reg - CNT_W'(1))),
        .rdata (stk_rdata)
    );

    assign idx_s = SLOT_W'(idx_reg);
    assign known = CMP_W'(idx_reg) < CMP_W'(hw_reg);

    // Operation decode and state update
    always_comb
    begin
        st        = ST_OK;
        slot_o    = idx_reg;
        cnt_o     = '0;
        off_en    = 1'b0;
        off_slot  = idx_s;
        freed     = 1'b0;
        grant     = stk_rdata;
        ref_we    = 1'b0;
        ref_waddr = idx_s;
        ref_wdata = cnt_rdata;
        stk_we    = 1'b0;
        stk_waddr = SLOT_W'(top_reg);
        top_next  = top_reg;
        hw_next   = hw_reg;
        used_next = used_reg;
        case (mode_reg)
            MODE_ALLOC:
            begin
                if (top_reg != '0)
                begin
                    grant    = stk_rdata;
                    top_next = top_reg - CNT_W'(1);
                end
                else if (hw_reg < CNT_W'(SLOT_COUNT))
                begin
                    grant   = SLOT_W'(hw_reg);
                    hw_next = hw_reg + CNT_W'(1);
                end
                else
                begin
                    st = ST_FULL;
                end
                if (st == ST_OK)
                begin
                    ref_we    = cmd.commit;
                    ref_waddr = grant;
                    ref_wdata = COUNT_ONE;
                    used_next = used_reg + CNT_W'(1);
                    cnt_o     = COUNT_ONE;
                    off_en    = 1'b1;
                    off_slot  = grant;
                    slot_o    = INDEX_W'(grant);
                end
                else
                begin
                    slot_o = '0;
                end
            end
            MODE_ADDREF:
            begin
                if (!known)
                begin
                    st = ST_NEVER;
                end
                else if (cnt_rdata == '0)
                begin
                    st = ST_FREE;
                end
                else if (cnt_rdata == COUNT_MAX)
                begin
                    st    = ST_SAT;
                    cnt_o = cnt_rdata;
                end
                else
                begin
                    ref_we    = cmd.commit;
                    ref_wdata = cnt_rdata + COUNT_ONE;
                    cnt_o     = cnt_rdata + COUNT_ONE;
                end
            end
            MODE_RELEASE:
            begin
                if (!known)
                begin
                    st = ST_NEVER;
                end
                else if (cnt_rdata == '0)
                begin
                    st = ST_FREE;
                end
                else
                begin
                    ref_we    = cmd.commit;
                    ref_wdata = cnt_rdata - COUNT_ONE;
                    cnt_o     = cnt_rdata - COUNT_ONE;
                    if (cnt_rdata == COUNT_ONE)
                    begin
                        freed = 1'b1;
                        if (top_reg < CNT_W'(SLOT_COUNT))
                        begin
                            stk_we   = cmd.commit;
                            top_next = top_reg + CNT_W'(1);
                        end
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - CNT_W'(1);
                        end
                    end
                end
            end
            MODE_OFFSET:
            begin
                if (!known)
                begin
                    st = ST_NEVER;
                end
                else if (cnt_rdata == '0)
                begin
                    st = ST_FREE;
                end
                else
                begin
                    cnt_o  = cnt_rdata;
                    off_en = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (!known)
                begin
                    st = ST_NEVER;
                end
                else
                begin
                    cnt_o = cnt_rdata;
                end
            end
            MODE_RESET:
            begin
                top_next  = '0;
                hw_next   = '0;
                used_next = '0;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    // Page byte offset, registered with the output word
    assign prod = 32'(off_slot) * 32'(PAGE_BYTES);

    // Pool counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            hw_reg   <= '0;
            used_reg <= '0;
        end
        else if (cmd.commit)
        begin
            top_reg  <= top_next;
            hw_reg   <= hw_next;
            used_reg <= used_next;
        end
    end

    // Input capture and output word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tdata[MODE_W-1:0];
            idx_reg  <= s_tdata[IN_BITS-1:MODE_W];
        end
        if (cmd.commit)
        begin
            status_reg   <= st;
            slot_reg     <= slot_o;
            refcnt_reg   <= REFCNT_W'(cnt_o);
            offset_reg   <= off_en ? prod[OFFSET_W-1:0] : '0;
            used_out_reg <= USED_W'(used_next);
            freed_reg    <= freed;
        end
    end

    assign m_tdata = OUT_W'({freed_reg, used_out_reg, offset_reg,
                             refcnt_reg, slot_reg, status_reg});

endmodule

// ===== rtl/rcsp_checker.sv =====
// ----------------------------------------------------------------------------
// rcsp_checker
// Port-level checks of the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_slot_pool_defines.svh"

module rcsp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rcsp_pkg::OUT_W-1:0] m_tdata
);

    import rcsp_pkg::*;

    logic                in_acc;
    logic                out_stall;
    logic [STATUS_W-1:0] st;
    logic                st_known;
    logic                freed_bit;
    logic                off_zero;

    assign in_acc    = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign st        = m_tdata[STATUS_W-1:0];
    assign st_known  = st inside {ST_OK, ST_FULL, ST_NEVER, ST_FREE, ST_SAT};
    assign freed_bit = m_tdata[58];
    assign off_zero  = (m_tdata[48:27] == '0);

    // Stalled result word holds
    `RCSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(m_tdata), "stalled word changed")

    // One command in work: no accept in the cycle after an accept
    `RCSP_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_acc, !s_tready, "second word accepted during update")

    // Status code is one of the defined codes
    `RCSP_ASSERT_IMPL(a_status_code, clk, rst_n, m_tvalid, st_known, "undefined status code")

    // A freed slot only comes with an ok status
    `RCSP_ASSERT_IMPL(a_freed_ok, clk, rst_n, m_tvalid && freed_bit, st == ST_OK, "slot freed with error status")

    // Error results carry no page offset
    `RCSP_ASSERT_IMPL(a_err_offset, clk, rst_n, m_tvalid && st != ST_OK, off_zero, "page offset on error status")

endmodule

bind refcounted_slot_pool rcsp_checker u_checker (.*);
